@@ hw/rtl/tss_pkg.sv @@
`timescale 1ns / 1ps

package tss_pkg;

   localparam int TOKEN_COUNT = 15;
   localparam int MAX_PAT_LEN = 10;
   localparam int REP_BYTES   = 6;
   localparam int PAT_LEN_W   = 4;
   localparam int REP_LEN_W   = 3;
   localparam int TOK_IDX_W   = 4;

   // one queued character: raw byte for copying, folded byte for matching
   typedef struct packed {
      logic [7:0] raw;
      logic [7:0] folded;
      logic       last;
   } tss_char_type;

   // event from the sequencer to the output stage
   typedef struct packed {
      logic       valid;
      logic       fin;
      logic [7:0] data;
      logic       dropped;
   } tss_evt_type;

   // lower-case patterns, right-justified, first character in the highest used byte
   localparam logic [8*MAX_PAT_LEN-1:0] TOK_PAT [TOKEN_COUNT] = '{
      80'(":)"), 80'(":("), 80'(":d"), 80'(";)"), 80'(":p"),
      80'(":o"), 80'(":/"), 80'("<3"), 80'(":heart:"), 80'(":thumbsup:"),
      80'("lol"), 80'("rofl"), 80'("wink"), 80'("cool"), 80'("cry")
   };

   localparam logic [PAT_LEN_W-1:0] TOK_PLEN [TOKEN_COUNT] = '{
      4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
      4'd7, 4'd10, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3
   };

   // replacement sequences, left-justified, first byte in the top byte
   localparam logic [8*REP_BYTES-1:0] TOK_REP [TOKEN_COUNT] = '{
      48'hF09F988A_0000, 48'hF09F989E_0000, 48'hF09F9883_0000,
      48'hF09F9889_0000, 48'hF09F989B_0000, 48'hF09F98AE_0000,
      48'hF09F9895_0000, 48'hE29DA4EFB88F,   48'hE29DA4EFB88F,
      48'hF09F918D_0000, 48'hF09F9882_0000, 48'hF09FA4A3_0000,
      48'hF09F9889_0000, 48'hF09F988E_0000, 48'hF09F98A2_0000
   };

   localparam logic [REP_LEN_W-1:0] TOK_RLEN [TOKEN_COUNT] = '{
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6,
      3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };

endpackage

@@ hw/rtl/tss_front.sv @@
`timescale 1ns / 1ps

module tss_front import tss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_in_byte,
   input  logic         req_in_last,
   output tss_char_type q_data,
   output logic         q_valid,
   input  logic         q_ready
);

   tss_char_type slot_ff [2];
   tss_char_type char_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   // case folding of ascii capitals
   always_comb begin
      char_in.raw    = req_in_byte;
      char_in.folded = (req_in_byte >= 8'h41 && req_in_byte <= 8'h5A) ?
                       (req_in_byte + 8'd32) : req_in_byte;
      char_in.last   = req_in_last;
   end

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= char_in;
      end
   end

endmodule

@@ hw/rtl/tss_back.sv @@
`timescale 1ns / 1ps

module tss_back import tss_pkg::*; #(
   parameter int WINDOW_LEN = 10,
   parameter int OUT_LIMIT  = 1023
) (
   input  logic         clock,
   input  logic         reset,
   input  tss_char_type q_data,
   input  logic         q_valid,
   output logic         q_ready,
   output tss_evt_type  evt,
   input  logic         evt_ready
);

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int CNT_W  = $clog2(OUT_LIMIT + 1);
   localparam int REP_W  = 8 * REP_BYTES;
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
   localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(OUT_LIMIT);

   typedef enum logic [3:0] {
      ST_LOAD   = 4'b0001,
      ST_DECIDE = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [7:0]             win_raw_ff [WINDOW_LEN];
   logic [7:0]             win_lc_ff  [WINDOW_LEN];
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic                   last_ff, last_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   dropped_ff, dropped_in;
   logic                   step_emit_ff, step_emit_in;
   logic [REP_W-1:0]       rep_ff, rep_in;
   logic [REP_LEN_W-1:0]   rem_ff, rem_in;
   logic [PAT_LEN_W-1:0]   shift_ff, shift_in;

   logic [TOKEN_COUNT-1:0] tok_hit;
   logic [TOK_IDX_W-1:0]   sel_idx;
   logic                   any_hit;
   logic                   load_en, shift_en;

   // token compare at the window head
   always_comb begin
      int idx;
      for (int t = 0; t < TOKEN_COUNT; t++) begin
         tok_hit[t] = (8'(TOK_PLEN[t]) <= 8'(fill_ff));
         for (int k = 0; k < MAX_PAT_LEN; k++) begin
            idx = int'(TOK_PLEN[t]) - 1 - k;
            if (k < int'(TOK_PLEN[t])) begin
               if (win_lc_ff[k] != TOK_PAT[t][idx*8 +: 8]) begin
                  tok_hit[t] = 1'b0;
               end
            end
         end
      end
   end

   // first entry in table order wins
   always_comb begin
      sel_idx = '0;
      for (int t = TOKEN_COUNT - 1; t >= 0; t--) begin
         if (tok_hit[t]) begin
            sel_idx = TOK_IDX_W'(t);
         end
      end
   end

   assign any_hit  = |tok_hit;
   assign q_ready  = (state_ff == ST_LOAD);
   assign load_en  = (state_ff == ST_LOAD) && q_valid;
   assign shift_en = (state_ff == ST_EMIT) && (shift_ff != '0);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      step_emit_in = step_emit_ff;
      rep_in       = rep_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      evt          = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               fill_in      = fill_ff + 1'b1;
               last_in      = q_data.last;
               step_emit_in = 1'b0;
               if (fill_in == FILL_FULL || q_data.last) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (any_hit) begin
               rep_in   = TOK_REP[sel_idx];
               rem_in   = TOK_RLEN[sel_idx];
               shift_in = TOK_PLEN[sel_idx];
            end else begin
               rep_in   = {win_raw_ff[0], (REP_W - 8)'(0)};
               rem_in   = REP_LEN_W'(1);
               shift_in = PAT_LEN_W'(1);
            end
            fill_in  = fill_ff - FILL_W'(shift_in);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rem_ff != '0) begin
               if (count_ff == CNT_LIMIT) begin
                  // output limit reached: byte is dropped
                  dropped_in = 1'b1;
                  rem_in     = rem_ff - 1'b1;
                  rep_in     = rep_ff << 8;
               end else begin
                  evt.valid = 1'b1;
                  evt.data  = rep_ff[REP_W-1 -: 8];
                  if (evt_ready) begin
                     count_in     = count_ff + 1'b1;
                     rem_in       = rem_ff - 1'b1;
                     rep_in       = rep_ff << 8;
                     step_emit_in = 1'b1;
                  end
               end
            end
            if (shift_ff != '0) begin
               shift_in = shift_ff - 1'b1;
            end
            if (rem_in == '0 && shift_in == '0) begin
               priority if (last_ff && fill_ff != '0) begin
                  state_in = ST_DECIDE;
               end else if (last_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_FINISH: begin
            if (!step_emit_ff) begin
               // final request fully dropped: zero byte goes out as the end marker
               evt.valid = 1'b1;
               evt.data  = 8'h00;
               if (evt_ready) begin
                  step_emit_in = 1'b1;
               end
            end else begin
               evt.valid   = 1'b1;
               evt.fin     = 1'b1;
               evt.dropped = dropped_ff;
               if (evt_ready) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  last_in    = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         last_ff      <= 1'b0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         step_emit_ff <= 1'b0;
         rem_ff       <= '0;
         shift_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         step_emit_ff <= step_emit_in;
         rem_ff       <= rem_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff <= rep_in;
   end

   // window: append at the fill point, drop the head one place per cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (load_en && fill_ff == FILL_W'(i)) begin
            win_raw_ff[i] <= q_data.raw;
            win_lc_ff[i]  <= q_data.folded;
         end else if (shift_en && i < WINDOW_LEN - 1) begin
            win_raw_ff[i] <= win_raw_ff[(i + 1) % WINDOW_LEN];
            win_lc_ff[i]  <= win_lc_ff[(i + 1) % WINDOW_LEN];
         end
      end
   end

endmodule

@@ hw/rtl/tss_out.sv @@
`timescale 1ns / 1ps

module tss_out import tss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tss_evt_type evt,
   output logic        evt_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_out_truncated
);

   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_trunc_ff, out_trunc_in;
   logic       out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign evt_ready = evt.fin ? out_free : (out_free || !hold_valid_ff);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_trunc_in  = out_trunc_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (evt.valid && evt_ready) begin
         if (evt.fin) begin
            // held byte becomes the final one, or a marker if nothing is held
            out_valid_in  = 1'b1;
            out_byte_in   = hold_valid_ff ? hold_byte_ff : 8'h00;
            out_last_in   = 1'b1;
            out_trunc_in  = hold_valid_ff ? evt.dropped : 1'b1;
            hold_valid_in = 1'b0;
         end else begin
            if (hold_valid_ff) begin
               out_valid_in = 1'b1;
               out_byte_in  = hold_byte_ff;
               out_last_in  = 1'b0;
               out_trunc_in = 1'b0;
            end
            hold_byte_in  = evt.data;
            hold_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_out_last      = out_last_ff;
   assign rsp_out_truncated = out_trunc_ff;

endmodule

@@ hw/rtl/token_substitution_stream_core.sv @@
`timescale 1ns / 1ps
// token substitution stream: message bytes in on req_, bytes out on rsp_
// a request carries one character and a flag for the last one of a message;
// each rsp_ item is one output byte, the final one of a message carries
// rsp_out_last, plus rsp_out_truncated if bytes were cut at the length limit
// requests land in a two-entry queue; the sequencer behind it appends each one
// to the lookahead window, and when the window is full or holds the message's
// last character it decides at the head: it matches all tokens, then it sends
// the output bytes (4 or 6 for a token, 1 for a copy) one per cycle unless the
// output stage stalls, while the window drops the consumed bytes one per cycle
// on the last request the window drains completely, then a finish step ends the
// message, after a lone zero marker if every byte of that request was dropped
// one output byte is held back until the next one or the message end arrives,
// so the final byte can carry its flags
// a stalled receiver backs up through the output register and hold byte into
// the sequencer and the queue, and req_ready drops once the queue is full
// reset clears the queue, the window fill, the counters and the output stage
module token_substitution_stream_core import tss_pkg::*; #(
   parameter int WINDOW_LEN = 10,
   parameter int OUT_LIMIT  = 1023
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_out_truncated
);

   tss_char_type q_data;
   logic         q_valid;
   logic         q_ready;
   tss_evt_type  evt;
   logic         evt_ready;

   // front: take requests, fold case, queue them
   tss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_data      (q_data),
      .q_valid     (q_valid),
      .q_ready     (q_ready)
   );

   // back: window, token match and byte sequencing with the length limit
   tss_back #(
      .WINDOW_LEN (WINDOW_LEN),
      .OUT_LIMIT  (OUT_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .evt       (evt),
      .evt_ready (evt_ready)
   );

   // output: hold byte for end marking, then the output register
   tss_out u_out (
      .clock             (clock),
      .reset             (reset),
      .evt               (evt),
      .evt_ready         (evt_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_out_truncated (rsp_out_truncated)
   );

`ifndef SYNTH
   // truncation is only ever reported on the final byte of a message
   a_trunc_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_last || !rsp_out_truncated))
      else $error("truncated flag on a non-final byte");

   // a message end taken by the output stage shows up as a final byte next cycle
   a_fin_gives_last: assert property (@(posedge clock) disable iff (reset)
      (evt.valid && evt.fin && evt_ready) |=> (rsp_valid && rsp_out_last))
      else $error("message end not presented as final byte");

   // the sequencer never emits while it is taking a character from the queue
   a_no_emit_on_load: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !evt.valid)
      else $error("emission during window load");
`endif

endmodule

@@ tb/sv/tss_tb_pkg.sv @@
`timescale 1ns / 1ps

package tss_tb_pkg;

   localparam int WIN_LEN     = 10;
   localparam int BYTE_CAP    = 1023;
   localparam int TOKEN_TOTAL = 15;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       truncated;
   } out_byte_type;

   // lower-case token text, in priority order
   function automatic string token_text(int idx);
      case (idx)
         0:       return ":)";
         1:       return ":(";
         2:       return ":d";
         3:       return ";)";
         4:       return ":p";
         5:       return ":o";
         6:       return ":/";
         7:       return "<3";
         8:       return ":heart:";
         9:       return ":thumbsup:";
         10:      return "lol";
         11:      return "rofl";
         12:      return "wink";
         13:      return "cool";
         default: return "cry";
      endcase
   endfunction

   // utf-8 replacement, first byte in the top byte
   function automatic void token_code(int idx, output logic [47:0] rep, output int rlen);
      rlen = 4;
      case (idx)
         0:       rep = 48'hF09F988A_0000;
         1:       rep = 48'hF09F989E_0000;
         2:       rep = 48'hF09F9883_0000;
         3:       rep = 48'hF09F9889_0000;
         4:       rep = 48'hF09F989B_0000;
         5:       rep = 48'hF09F98AE_0000;
         6:       rep = 48'hF09F9895_0000;
         7, 8: begin
            rep  = 48'hE29DA4_EFB88F;
            rlen = 6;
         end
         9:       rep = 48'hF09F918D_0000;
         10:      rep = 48'hF09F9882_0000;
         11:      rep = 48'hF09FA4A3_0000;
         12:      rep = 48'hF09F9889_0000;
         13:      rep = 48'hF09F988E_0000;
         default: rep = 48'hF09F98A2_0000;
      endcase
   endfunction

   class substitution_scoreboard;
      out_byte_type owed_bytes[$];
      logic [7:0]   window[WIN_LEN];
      int           fill;
      int           sent_count;
      bit           cut;
      int           step_count;
      int           errors;

      function new();
         fill       = 0;
         sent_count = 0;
         cut        = 0;
         step_count = 0;
         errors     = 0;
      endfunction

      function int owed();
         return owed_bytes.size();
      endfunction

      function logic [7:0] lower_of(logic [7:0] c);
         return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      endfunction

      // one output byte, unless the message already hit the cap
      function void emit_byte(logic [7:0] b);
         if (sent_count >= BYTE_CAP) begin
            cut = 1'b1;
         end else begin
            owed_bytes.push_back('{b, 1'b0, 1'b0});
            sent_count++;
            step_count++;
         end
      endfunction

      // first matching token at the window head wins, else copy the head byte
      function void substitute_head();
         int          used;
         bit          hit;
         string       pat;
         logic [47:0] rep;
         int          rlen;
         used = 1;
         hit  = 1'b0;
         for (int i = 0; i < TOKEN_TOTAL && !hit; i++) begin
            pat = token_text(i);
            if (pat.len() <= fill) begin
               hit = 1'b1;
               for (int k = 0; k < pat.len(); k++) begin
                  if (lower_of(window[k]) != pat[k]) hit = 1'b0;
               end
               if (hit) begin
                  token_code(i, rep, rlen);
                  for (int k = 0; k < rlen; k++) emit_byte(rep[47 - 8*k -: 8]);
                  used = pat.len();
               end
            end
         end
         if (!hit) emit_byte(window[0]);
         if (used > fill) used = fill;
         for (int k = 0; k < fill - used; k++) window[k] = window[k + used];
         fill -= used;
      endfunction

      function void note_char(logic [7:0] b, logic last);
         out_byte_type tail;
         step_count = 0;
         if (fill >= WIN_LEN) substitute_head();
         window[fill] = b;
         fill++;
         while (fill >= WIN_LEN || (last && fill > 0)) substitute_head();
         if (last) begin
            if (step_count == 0) begin
               owed_bytes.push_back('{8'h00, 1'b1, 1'b1});
            end else begin
               tail           = owed_bytes[owed_bytes.size() - 1];
               tail.last      = 1'b1;
               tail.truncated = cut;
               owed_bytes[owed_bytes.size() - 1] = tail;
            end
            fill       = 0;
            sent_count = 0;
            cut        = 1'b0;
         end
      endfunction

      function void check_byte(logic [7:0] b, logic last, logic truncated);
         out_byte_type want;
         if (owed_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte, actual data %h last %b truncated %b",
                     $time, b, last, truncated);
            return;
         end
         want = owed_bytes.pop_front();
         if (want.data !== b) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data, b);
         end
         if (want.last !== last) begin
            errors++;
            $display("%0t: out_last expected %b actual %b", $time, want.last, last);
         end
         if (want.truncated !== truncated) begin
            errors++;
            $display("%0t: out_truncated expected %b actual %b",
                     $time, want.truncated, truncated);
         end
      endfunction
   endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tss_tb_pkg::*;

   // generous bound on the slowest legal run, long messages included
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 100;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte       = 8'h00;
   logic       req_in_last       = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_out_truncated;

   substitution_scoreboard subst_sb;

   bit idle_on    = 1'b0;
   int stall_left = 0;
   int items_sent = 0;
   int cycles     = 0;

   token_substitution_stream_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_in_last       (req_in_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_out_truncated (rsp_out_truncated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // both handshakes are sampled at the rising edge; a request is predicted
   // before any byte of the same edge is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) subst_sb.note_char(req_in_byte, req_in_last);
         if (rsp_valid && rsp_ready)
            subst_sb.check_byte(rsp_out_byte, rsp_out_last, rsp_out_truncated);
      end
   end

   // receiver back-pressure: random stall bursts while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request; called at a falling edge, returns at the falling edge after
   // the accepting rising edge so valid stays high between back-to-back requests
   task automatic send_char(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // whole message, end flag on its final character
   task automatic send_message(input byte_q_type msg);
      for (int i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
   endtask

   task automatic send_text(input string s);
      byte_q_type msg;
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
      send_message(msg);
   endtask

   // hold the sender until every predicted byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (subst_sb.owed() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // random upper case on the letters of a token
   function automatic string scramble_case(string s);
      string      r;
      logic [7:0] c;
      r = s;
      for (int i = 0; i < r.len(); i++) begin
         c = r[i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) r[i] = c - 8'd32;
      end
      return r;
   endfunction

   initial begin
      byte_q_type msg;
      string      s;
      int         target;
      int         pick;
      int         cut_len;
      int         random_start;
      bit         paused;
      subst_sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // directed: byte extremes with the zero byte copied through
      msg = '{8'h00, 8'hFF, 8'h01};
      send_message(msg);
      // single-character message
      send_text("Q");
      send_text("<3");
      // longest token filling the whole window, mixed case
      send_text(":Thumbsup:");
      send_text(":HeArT:");
      send_text("LoL");
      wait_drained();

      // length cap reached before the final request: lone end marker
      msg.delete();
      repeat (176) begin
         msg.push_back("<");
         msg.push_back("3");
      end
      send_message(msg);
      // next message must start from a cleared count
      send_text(":)x");
      wait_drained();

      // random messages: mostly tokens and text, some broken tokens and noise
      random_start = items_sent;
      paused       = 1'b0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (items_sent - random_start >= RANDOM_ITEMS - 40) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 3) != 0);
         msg.delete();
         target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                              : $urandom_range(1, 24);
         while (msg.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               s = scramble_case(token_text($urandom_range(0, TOKEN_TOTAL - 1)));
               for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
            end else if (pick < 80) begin
               msg.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 90) begin
               // token prefix, cut before its last character
               s       = scramble_case(token_text($urandom_range(0, TOKEN_TOTAL - 1)));
               cut_len = $urandom_range(1, s.len() - 1);
               for (int i = 0; i < cut_len; i++) msg.push_back(s[i]);
            end else begin
               msg.push_back(8'($urandom_range(1, 255)));
            end
         end
         send_message(msg);
         if (!paused && items_sent - random_start >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      // drain with no back-pressure, then watch for stray bytes
      idle_on = 1'b0;
      req_valid <= 1'b0;
      while (subst_sb.owed() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (subst_sb.errors == 0 && subst_sb.owed() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tss_pkg.sv
hw/rtl/tss_front.sv
hw/rtl/tss_back.sv
hw/rtl/tss_out.sv
hw/rtl/token_substitution_stream_core.sv
tb/sv/tss_tb_pkg.sv
tb/sv/tb_top.sv
